/* design/ddpp_pkg.sv */
// ----------------------------------------------------------------------------
// ddpp_pkg: shared types and constants for the DER DH parameter parser
// Parse phases, status codes, field codes and the result record.
// ----------------------------------------------------------------------------
package ddpp_pkg;

  localparam int LEN_WIDTH      = 16;
  localparam int MAX_LEN_OCTETS = 4;

  // result queue, power-of-two depth
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  typedef logic [LEN_WIDTH-1:0] len_t;
  typedef logic [RQ_PTR_W-1:0]  rq_ptr_t;
  typedef logic [RQ_PTR_W:0]    rq_count_t;

  typedef enum logic [3:0] {
    PH_SEQ_TAG      = 4'd0,
    PH_SEQ_LEN      = 4'd1,
    PH_SEQ_LEN_MORE = 4'd2,
    PH_INT_TAG      = 4'd3,
    PH_INT_LEN      = 4'd4,
    PH_INT_LEN_MORE = 4'd5,
    PH_INT_VALUE    = 4'd6,
    PH_DONE         = 4'd7,
    PH_FAILED       = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_WRONG_TAG = 3'd1,
    ST_BAD_FORM  = 3'd2,
    ST_OVERRUN   = 3'd3,
    ST_EMPTY_INT = 3'd4,
    ST_TRUNCATED = 3'd5,
    ST_TRAILING  = 3'd6
  } status_t;

  localparam logic [1:0] FIELD_P = 2'd0;
  localparam logic [1:0] FIELD_G = 2'd1;
  localparam logic [1:0] FIELD_Q = 2'd2;

  typedef struct packed {
    logic       is_status;
    logic [1:0] field_id;
    logic [7:0] value_byte;
    logic       last_of_field;
    status_t    status;
    logic       q_present;
    len_t       p_length;
    len_t       g_length;
    len_t       q_length;
    logic       last_of_run;
  } result_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic    val_valid;
    result_t val;
    logic    stat_valid;
    result_t stat;
  } step_t;

endpackage

/* design/ddpp_stream_if.sv */
// ----------------------------------------------------------------------------
// ddpp stream interfaces
// Valid/ready channels for input bytes and parser results.
// ----------------------------------------------------------------------------
interface ddpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source(output valid, data_byte, end_of_buffer, input ready);
  modport sink(input valid, data_byte, end_of_buffer, output ready);
endinterface

interface ddpp_out_if;
  logic                 valid;
  logic                 ready;
  logic                 is_status;
  logic [1:0]           field_id;
  logic [7:0]           value_byte;
  logic                 last_of_field;
  logic [2:0]           status;
  logic                 q_present;
  ddpp_pkg::len_t       p_length;
  ddpp_pkg::len_t       g_length;
  ddpp_pkg::len_t       q_length;
  logic                 last_of_run;

  modport source(output valid, is_status, field_id, value_byte, last_of_field, status,
                 q_present, p_length, g_length, q_length, last_of_run, input ready);
  modport sink(input valid, is_status, field_id, value_byte, last_of_field, status,
               q_present, p_length, g_length, q_length, last_of_run, output ready);
endinterface

/* design/ddpp_core.sv */
// ----------------------------------------------------------------------------
// ddpp_core: byte-serial DER TLV parse step
// Holds the parse state and computes the results of one byte.
// ----------------------------------------------------------------------------
module ddpp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_buffer,
  output ddpp_pkg::step_t   step
);

  ddpp_pkg::phase_t phase, phase_next;
  ddpp_pkg::len_t   acc, acc_next;
  logic             acc_ovf, acc_ovf_next;
  logic [2:0]       len_left, len_left_next;
  ddpp_pkg::len_t   seq_rem, seq_rem_next;
  ddpp_pkg::len_t   elem_rem, elem_rem_next;
  logic [1:0]       field, field_next;
  logic             first, first_next;
  ddpp_pkg::status_t err, err_next;
  ddpp_pkg::len_t   p_len, p_len_next;
  ddpp_pkg::len_t   g_len, g_len_next;
  ddpp_pkg::len_t   q_len, q_len_next;
  logic             q_seen, q_seen_next;

  logic             do_finish;
  ddpp_pkg::len_t   fin_len;
  logic             fin_big;
  logic             in_seq;
  logic [6:0]       n_oct;
  logic             emit;
  logic             emit_last;
  ddpp_pkg::status_t st;

  assign in_seq = (phase == ddpp_pkg::PH_SEQ_LEN) || (phase == ddpp_pkg::PH_SEQ_LEN_MORE);
  assign n_oct  = data_byte[6:0];

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    acc_ovf_next  = acc_ovf;
    len_left_next = len_left;
    seq_rem_next  = seq_rem;
    elem_rem_next = elem_rem;
    field_next    = field;
    first_next    = first;
    err_next      = err;
    p_len_next    = p_len;
    g_len_next    = g_len;
    q_len_next    = q_len;
    q_seen_next   = q_seen;
    do_finish     = 1'b0;
    fin_len       = '0;
    fin_big       = 1'b0;
    emit          = 1'b0;
    emit_last     = 1'b0;

    case (phase)
      ddpp_pkg::PH_SEQ_TAG: begin
        if (data_byte != ddpp_pkg::TAG_SEQUENCE) begin
          err_next   = ddpp_pkg::ST_WRONG_TAG;
          phase_next = ddpp_pkg::PH_FAILED;
        end else begin
          phase_next = ddpp_pkg::PH_SEQ_LEN;
        end
      end
      ddpp_pkg::PH_SEQ_LEN, ddpp_pkg::PH_INT_LEN: begin
        if (!in_seq) seq_rem_next = seq_rem - 1'b1;
        if (data_byte[7]) begin
          if (n_oct == '0 || n_oct > 7'(ddpp_pkg::MAX_LEN_OCTETS)) begin
            err_next   = ddpp_pkg::ST_BAD_FORM;
            phase_next = ddpp_pkg::PH_FAILED;
          end else if (!in_seq && ddpp_pkg::len_t'(n_oct) > seq_rem_next) begin
            err_next   = ddpp_pkg::ST_OVERRUN;
            phase_next = ddpp_pkg::PH_FAILED;
          end else begin
            len_left_next = n_oct[2:0];
            acc_next      = '0;
            acc_ovf_next  = 1'b0;
            phase_next    = in_seq ? ddpp_pkg::PH_SEQ_LEN_MORE : ddpp_pkg::PH_INT_LEN_MORE;
          end
        end else begin
          do_finish = 1'b1;
          fin_len   = ddpp_pkg::len_t'(data_byte);
        end
      end
      ddpp_pkg::PH_SEQ_LEN_MORE, ddpp_pkg::PH_INT_LEN_MORE: begin
        if (!in_seq) seq_rem_next = seq_rem - 1'b1;
        acc_next      = {acc[ddpp_pkg::LEN_WIDTH-9:0], data_byte};
        acc_ovf_next  = acc_ovf | (acc[ddpp_pkg::LEN_WIDTH-1:ddpp_pkg::LEN_WIDTH-8] != '0);
        len_left_next = len_left - 1'b1;
        if (len_left_next == '0) begin
          do_finish = 1'b1;
          fin_len   = acc_next;
          fin_big   = acc_ovf_next;
        end
      end
      ddpp_pkg::PH_INT_TAG: begin
        if (data_byte != ddpp_pkg::TAG_INTEGER) begin
          err_next   = ddpp_pkg::ST_WRONG_TAG;
          phase_next = ddpp_pkg::PH_FAILED;
        end else begin
          seq_rem_next = seq_rem - 1'b1;
          if (seq_rem_next == '0) begin
            err_next   = ddpp_pkg::ST_OVERRUN;
            phase_next = ddpp_pkg::PH_FAILED;
          end else begin
            phase_next = ddpp_pkg::PH_INT_LEN;
          end
        end
      end
      ddpp_pkg::PH_INT_VALUE: begin
        seq_rem_next  = seq_rem - 1'b1;
        elem_rem_next = elem_rem - 1'b1;
        first_next    = 1'b0;
        if (first && elem_rem > ddpp_pkg::len_t'(1) && data_byte == ddpp_pkg::BYTE_ZERO) begin
          // leading sign byte dropped
          case (field)
            ddpp_pkg::FIELD_P: p_len_next = p_len - 1'b1;
            ddpp_pkg::FIELD_G: g_len_next = g_len - 1'b1;
            default:           q_len_next = q_len - 1'b1;
          endcase
        end else begin
          emit      = 1'b1;
          emit_last = (elem_rem_next == '0);
          if (emit_last) begin
            if (seq_rem_next == '0) begin
              if (field == ddpp_pkg::FIELD_P) begin
                err_next   = ddpp_pkg::ST_OVERRUN;
                phase_next = ddpp_pkg::PH_FAILED;
              end else begin
                if (field == ddpp_pkg::FIELD_Q) q_seen_next = 1'b1;
                phase_next = ddpp_pkg::PH_DONE;
              end
            end else if (field >= ddpp_pkg::FIELD_Q) begin
              err_next   = ddpp_pkg::ST_TRAILING;
              phase_next = ddpp_pkg::PH_FAILED;
            end else begin
              field_next = field + 1'b1;
              phase_next = ddpp_pkg::PH_INT_TAG;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (do_finish) begin
      if (fin_big) begin
        err_next   = ddpp_pkg::ST_OVERRUN;
        phase_next = ddpp_pkg::PH_FAILED;
      end else if (in_seq) begin
        if (fin_len == '0) begin
          err_next   = ddpp_pkg::ST_OVERRUN;
          phase_next = ddpp_pkg::PH_FAILED;
        end else begin
          seq_rem_next = fin_len;
          field_next   = ddpp_pkg::FIELD_P;
          phase_next   = ddpp_pkg::PH_INT_TAG;
        end
      end else if (fin_len == '0) begin
        err_next   = ddpp_pkg::ST_EMPTY_INT;
        phase_next = ddpp_pkg::PH_FAILED;
      end else if (fin_len > seq_rem_next) begin
        err_next   = ddpp_pkg::ST_OVERRUN;
        phase_next = ddpp_pkg::PH_FAILED;
      end else begin
        elem_rem_next = fin_len;
        first_next    = 1'b1;
        phase_next    = ddpp_pkg::PH_INT_VALUE;
        case (field)
          ddpp_pkg::FIELD_P: p_len_next = fin_len;
          ddpp_pkg::FIELD_G: g_len_next = fin_len;
          default:           q_len_next = fin_len;
        endcase
      end
    end
  end

  always_comb begin
    st = err_next;
    if (st == ddpp_pkg::ST_OK && phase_next != ddpp_pkg::PH_DONE) st = ddpp_pkg::ST_TRUNCATED;

    step.val_valid           = accept && emit;
    step.val                 = '0;
    step.val.field_id        = field;
    step.val.value_byte      = data_byte;
    step.val.last_of_field   = emit_last;
    step.val.last_of_run     = !end_of_buffer;

    step.stat_valid          = accept && end_of_buffer;
    step.stat                = '0;
    step.stat.is_status      = 1'b1;
    step.stat.status         = st;
    step.stat.last_of_run    = 1'b1;
    if (st == ddpp_pkg::ST_OK) begin
      step.stat.q_present = q_seen_next;
      step.stat.p_length  = p_len_next;
      step.stat.g_length  = g_len_next;
      step.stat.q_length  = q_seen_next ? q_len_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_buffer)) begin
      phase    <= ddpp_pkg::PH_SEQ_TAG;
      acc      <= '0;
      acc_ovf  <= 1'b0;
      len_left <= '0;
      seq_rem  <= '0;
      elem_rem <= '0;
      field    <= ddpp_pkg::FIELD_P;
      first    <= 1'b0;
      err      <= ddpp_pkg::ST_OK;
      p_len    <= '0;
      g_len    <= '0;
      q_len    <= '0;
      q_seen   <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      acc      <= acc_next;
      acc_ovf  <= acc_ovf_next;
      len_left <= len_left_next;
      seq_rem  <= seq_rem_next;
      elem_rem <= elem_rem_next;
      field    <= field_next;
      first    <= first_next;
      err      <= err_next;
      p_len    <= p_len_next;
      g_len    <= g_len_next;
      q_len    <= q_len_next;
      q_seen   <= q_seen_next;
    end
  end

endmodule

/* design/der_dh_domain_parameter_parser_top.sv */
// ----------------------------------------------------------------------------
// der_dh_domain_parameter_parser_top: DER DH domain parameter parser
// Parses SEQUENCE{INTEGER p, INTEGER g [, INTEGER q]} a byte at a time.
//
//   channel  dir  payload
//   stream   in   data_byte, end_of_buffer
//   result   out  is_status, field_id, value_byte, last_of_field, status,
//                 q_present, p_length, g_length, q_length, last_of_run
//
// One byte per cycle while stream.ready is high, i.e. while the 4-entry result
// queue has room for two; the parse step is combinational from state registers
// and yields 0, 1 or 2 results per byte. Results leave one per cycle while result.ready is high.
// Synchronous reset clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
module der_dh_domain_parameter_parser_top (
  input  logic           clk,
  input  logic           rst,
  ddpp_in_if.sink        stream,
  ddpp_out_if.source     result
);

  ddpp_pkg::step_t     step;
  ddpp_pkg::result_t   queue [ddpp_pkg::RQ_DEPTH];
  ddpp_pkg::result_t   head;
  ddpp_pkg::rq_ptr_t   wr_ptr, rd_ptr;
  ddpp_pkg::rq_count_t count, count_next;
  logic                accept, pop;
  logic [1:0]          push_n;

  // room for the two results one byte can yield
  assign stream.ready = (count <= ddpp_pkg::rq_count_t'(ddpp_pkg::RQ_DEPTH - 2));
  assign accept       = stream.valid && stream.ready;
  assign pop          = result.valid && result.ready;
  assign push_n       = {1'b0, step.val_valid} + {1'b0, step.stat_valid};
  assign count_next   = count + ddpp_pkg::rq_count_t'(push_n) - ddpp_pkg::rq_count_t'(pop);

  ddpp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (stream.data_byte),
    .end_of_buffer (stream.end_of_buffer),
    .step          (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ddpp_pkg::rq_ptr_t'(push_n);
      rd_ptr <= rd_ptr + ddpp_pkg::rq_ptr_t'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step.val_valid) begin
      queue[wr_ptr] <= step.val;
      if (step.stat_valid) queue[wr_ptr + ddpp_pkg::rq_ptr_t'(1)] <= step.stat;
    end else if (step.stat_valid) begin
      queue[wr_ptr] <= step.stat;
    end
  end

  assign head = queue[rd_ptr];

  assign result.valid         = (count != '0);
  assign result.is_status     = head.is_status;
  assign result.field_id      = head.field_id;
  assign result.value_byte    = head.value_byte;
  assign result.last_of_field = head.last_of_field;
  assign result.status        = head.status;
  assign result.q_present     = head.q_present;
  assign result.p_length      = head.p_length;
  assign result.g_length      = head.g_length;
  assign result.q_length      = head.q_length;
  assign result.last_of_run   = head.last_of_run;

endmodule

/* design/ddpp_checker.sv */
// ----------------------------------------------------------------------------
// ddpp_checker: port-level checks for the DER DH parameter parser
// Checks result record consistency and output transaction hold.
// ----------------------------------------------------------------------------
module ddpp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 is_status,
  input logic [1:0]           field_id,
  input logic [7:0]           value_byte,
  input logic                 last_of_field,
  input logic [2:0]           status,
  input logic                 q_present,
  input ddpp_pkg::len_t       p_length,
  input ddpp_pkg::len_t       g_length,
  input ddpp_pkg::len_t       q_length,
  input logic                 last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_value_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> status == 3'd0 && !q_present && p_length == '0 &&
      g_length == '0 && q_length == '0 && field_id != 2'd3)
    else $error("value result carries status fields");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> last_of_run && field_id == 2'd0 && value_byte == 8'd0 &&
      !last_of_field && status != 3'd7)
    else $error("status result malformed");

  a_error_no_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status && status != 3'd0 |-> !q_present && p_length == '0 &&
      g_length == '0 && q_length == '0)
    else $error("error status carries lengths");

  a_q_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status && !q_present |-> q_length == '0)
    else $error("q length without q");

endmodule

bind der_dh_domain_parameter_parser_top ddpp_checker u_ddpp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .is_status     (result.is_status),
  .field_id      (result.field_id),
  .value_byte    (result.value_byte),
  .last_of_field (result.last_of_field),
  .status        (result.status),
  .q_present     (result.q_present),
  .p_length      (result.p_length),
  .g_length      (result.g_length),
  .q_length      (result.q_length),
  .last_of_run   (result.last_of_run)
);
